@@ rtl/hpc_pkg.sv @@
// Package for the 16-bit prefix-operand accumulator core: payload structs,
// microcode word format, microprogram ROM and opcode dispatch table.
// No dependencies; every other file in rtl/ imports it.
package hpc_pkg;

  // default memory depth in words
  localparam int unsigned HPC_MEM_WORDS = 32768;

  // micro-program counter width
  localparam int unsigned UPC_W = 5;

  // request and response payloads
  typedef struct packed {
    logic        req_type;
    logic [14:0] load_addr;
    logic [15:0] load_data;
    logic [15:0] in_data;
  } req_t;

  typedef struct packed {
    logic [15:0] pc_now;
    logic [15:0] a_now;
    logic [15:0] b_now;
    logic        out_valid;
    logic [15:0] out_word;
    logic [15:0] out_port;
    logic        in_taken;
    logic [15:0] in_port;
  } rsp_t;

  // request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EXEC = 1'b1;

  // instruction opcodes (high nibble)
  localparam logic [3:0] OP_LDAM  = 4'h0;
  localparam logic [3:0] OP_LDBM  = 4'h1;
  localparam logic [3:0] OP_STAM  = 4'h2;
  localparam logic [3:0] OP_LDAC  = 4'h3;
  localparam logic [3:0] OP_LDBC  = 4'h4;
  localparam logic [3:0] OP_LDAP  = 4'h5;
  localparam logic [3:0] OP_LDAI  = 4'h6;
  localparam logic [3:0] OP_LDBI  = 4'h7;
  localparam logic [3:0] OP_STAI  = 4'h8;
  localparam logic [3:0] OP_BR    = 4'h9;
  localparam logic [3:0] OP_BRZ   = 4'hA;
  localparam logic [3:0] OP_BRN   = 4'hB;
  localparam logic [3:0] OP_BRB   = 4'hC;
  localparam logic [3:0] OP_OPR   = 4'hD;
  localparam logic [3:0] OP_PFIX  = 4'hE;
  localparam logic [3:0] OP_NFIX  = 4'hF;

  // operate sub-codes (operand value)
  localparam logic [15:0] OPR_ADD = 16'h0000;
  localparam logic [15:0] OPR_SUB = 16'h0001;
  localparam logic [15:0] OPR_IN  = 16'h0002;
  localparam logic [15:0] OPR_OUT = 16'h0003;

  // high byte forced by a negative prefix
  localparam logic [15:0] NFIX_MASK = 16'hFF00;

  // sequencing field
  typedef enum logic [2:0] {
    SQ_ACCEPT,
    SQ_NEXT,
    SQ_JUMP,
    SQ_DISPATCH,
    SQ_FIN
  } seq_t;

  // memory address source
  typedef enum logic [1:0] {
    ADDR_REQ,
    ADDR_O,
    ADDR_AO,
    ADDR_BO
  } addr_sel_t;

  // memory write data source
  typedef enum logic {
    WD_A,
    WD_LOAD
  } wd_sel_t;

  // register transfer performed in a step
  typedef enum logic [3:0] {
    RO_NONE,
    RO_DECODE,
    RO_A_MEM,
    RO_B_MEM,
    RO_A_OPR,
    RO_B_OPR,
    RO_A_PCREL,
    RO_PC_REL,
    RO_PC_REL_Z,
    RO_PC_REL_N,
    RO_PC_BREL,
    RO_OPERATE,
    RO_PFX,
    RO_NFX,
    RO_CLR
  } reg_op_t;

  // one microcode word
  typedef struct packed {
    seq_t             seq;
    logic [UPC_W-1:0] target;
    logic             addr_en;
    addr_sel_t        addr_sel;
    logic             mem_rd;
    logic             mem_wr;
    wd_sel_t          wd_sel;
    reg_op_t          reg_op;
  } uword_t;

  // control from sequencer to datapath
  typedef struct packed {
    logic      addr_en;
    addr_sel_t addr_sel;
    logic      latch_req;
    logic      mem_rd;
    logic      mem_wr;
    wd_sel_t   wd_sel;
    reg_op_t   reg_op;
    logic      commit;
  } ctl_t;

  // microprogram addresses
  localparam logic [UPC_W-1:0] UA_IDLE   = 5'd0;
  localparam logic [UPC_W-1:0] UA_LWR    = 5'd1;
  localparam logic [UPC_W-1:0] UA_FETCH  = 5'd2;
  localparam logic [UPC_W-1:0] UA_DECODE = 5'd3;
  localparam logic [UPC_W-1:0] UA_LDA_AD = 5'd4;
  localparam logic [UPC_W-1:0] UA_LDA_RD = 5'd5;
  localparam logic [UPC_W-1:0] UA_LDA_WB = 5'd6;
  localparam logic [UPC_W-1:0] UA_LDB_AD = 5'd7;
  localparam logic [UPC_W-1:0] UA_LDB_RD = 5'd8;
  localparam logic [UPC_W-1:0] UA_LDB_WB = 5'd9;
  localparam logic [UPC_W-1:0] UA_STA_AD = 5'd10;
  localparam logic [UPC_W-1:0] UA_STA_WR = 5'd11;
  localparam logic [UPC_W-1:0] UA_LDAC   = 5'd12;
  localparam logic [UPC_W-1:0] UA_LDBC   = 5'd13;
  localparam logic [UPC_W-1:0] UA_LDAP   = 5'd14;
  localparam logic [UPC_W-1:0] UA_LDAI   = 5'd15;
  localparam logic [UPC_W-1:0] UA_LDBI   = 5'd16;
  localparam logic [UPC_W-1:0] UA_STAI   = 5'd17;
  localparam logic [UPC_W-1:0] UA_BR     = 5'd18;
  localparam logic [UPC_W-1:0] UA_BRZ    = 5'd19;
  localparam logic [UPC_W-1:0] UA_BRN    = 5'd20;
  localparam logic [UPC_W-1:0] UA_BRB    = 5'd21;
  localparam logic [UPC_W-1:0] UA_OPR    = 5'd22;
  localparam logic [UPC_W-1:0] UA_PFIX   = 5'd23;
  localparam logic [UPC_W-1:0] UA_NFIX   = 5'd24;

  localparam uword_t UW_NOP = '{
    seq:      SQ_JUMP,
    target:   UA_IDLE,
    addr_en:  1'b0,
    addr_sel: ADDR_REQ,
    mem_rd:   1'b0,
    mem_wr:   1'b0,
    wd_sel:   WD_A,
    reg_op:   RO_NONE
  };

  // microprogram ROM
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    w = UW_NOP;
    case (upc)
      UA_IDLE:   begin w.seq = SQ_ACCEPT; w.addr_sel = ADDR_REQ; end
      UA_LWR:    begin w.seq = SQ_FIN; w.mem_wr = 1'b1; w.wd_sel = WD_LOAD; end
      UA_FETCH:  begin w.seq = SQ_NEXT; w.mem_rd = 1'b1; end
      UA_DECODE: begin w.seq = SQ_DISPATCH; w.reg_op = RO_DECODE; end
      UA_LDA_AD: begin w.seq = SQ_NEXT; w.addr_en = 1'b1; w.addr_sel = ADDR_O; end
      UA_LDA_RD: begin w.seq = SQ_NEXT; w.mem_rd = 1'b1; end
      UA_LDA_WB: begin w.seq = SQ_FIN; w.reg_op = RO_A_MEM; end
      UA_LDB_AD: begin w.seq = SQ_NEXT; w.addr_en = 1'b1; w.addr_sel = ADDR_O; end
      UA_LDB_RD: begin w.seq = SQ_NEXT; w.mem_rd = 1'b1; end
      UA_LDB_WB: begin w.seq = SQ_FIN; w.reg_op = RO_B_MEM; end
      UA_STA_AD: begin w.seq = SQ_NEXT; w.addr_en = 1'b1; w.addr_sel = ADDR_O; end
      UA_STA_WR: begin
        w.seq = SQ_FIN; w.mem_wr = 1'b1; w.wd_sel = WD_A; w.reg_op = RO_CLR;
      end
      UA_LDAC:   begin w.seq = SQ_FIN; w.reg_op = RO_A_OPR; end
      UA_LDBC:   begin w.seq = SQ_FIN; w.reg_op = RO_B_OPR; end
      UA_LDAP:   begin w.seq = SQ_FIN; w.reg_op = RO_A_PCREL; end
      UA_LDAI:   begin
        w.seq = SQ_JUMP; w.target = UA_LDA_RD; w.addr_en = 1'b1; w.addr_sel = ADDR_AO;
      end
      UA_LDBI:   begin
        w.seq = SQ_JUMP; w.target = UA_LDB_RD; w.addr_en = 1'b1; w.addr_sel = ADDR_BO;
      end
      UA_STAI:   begin
        w.seq = SQ_JUMP; w.target = UA_STA_WR; w.addr_en = 1'b1; w.addr_sel = ADDR_BO;
      end
      UA_BR:     begin w.seq = SQ_FIN; w.reg_op = RO_PC_REL; end
      UA_BRZ:    begin w.seq = SQ_FIN; w.reg_op = RO_PC_REL_Z; end
      UA_BRN:    begin w.seq = SQ_FIN; w.reg_op = RO_PC_REL_N; end
      UA_BRB:    begin w.seq = SQ_FIN; w.reg_op = RO_PC_BREL; end
      UA_OPR:    begin w.seq = SQ_FIN; w.reg_op = RO_OPERATE; end
      UA_PFIX:   begin w.seq = SQ_FIN; w.reg_op = RO_PFX; end
      UA_NFIX:   begin w.seq = SQ_FIN; w.reg_op = RO_NFX; end
      default:   w = UW_NOP;
    endcase
    return w;
  endfunction

  // opcode to microprogram entry
  function automatic logic [UPC_W-1:0] dispatch(input logic [3:0] opcode);
    logic [UPC_W-1:0] t;
    t = UA_IDLE;
    unique case (opcode)
      OP_LDAM: t = UA_LDA_AD;
      OP_LDBM: t = UA_LDB_AD;
      OP_STAM: t = UA_STA_AD;
      OP_LDAC: t = UA_LDAC;
      OP_LDBC: t = UA_LDBC;
      OP_LDAP: t = UA_LDAP;
      OP_LDAI: t = UA_LDAI;
      OP_LDBI: t = UA_LDBI;
      OP_STAI: t = UA_STAI;
      OP_BR:   t = UA_BR;
      OP_BRZ:  t = UA_BRZ;
      OP_BRN:  t = UA_BRN;
      OP_BRB:  t = UA_BRB;
      OP_OPR:  t = UA_OPR;
      OP_PFIX: t = UA_PFIX;
      OP_NFIX: t = UA_NFIX;
      default: t = UA_IDLE;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/hpc_addr_red.sv @@
// Word address reduction: registers a 16-bit address and yields it modulo
// MEM_WORDS in the following cycle. Depends on hpc_pkg for the default depth.
module hpc_addr_red
  import hpc_pkg::*;
#(
  parameter int unsigned MEM_WORDS = HPC_MEM_WORDS,
  localparam int unsigned AW = $clog2(MEM_WORDS)
) (
  input  logic          clk,
  input  logic          load,
  input  logic [15:0]   raw,
  output logic [AW-1:0] idx
);

  logic [15:0] raw_r;

  // address capture
  always_ff @(posedge clk) begin
    if (load) begin
      raw_r <= raw;
    end
  end

  generate
    if ((MEM_WORDS & (MEM_WORDS - 1)) == 0) begin : g_pow2
      // power-of-two depth: plain mask
      assign idx = raw_r[AW-1:0];
    end else begin : g_recip
      localparam int unsigned QW = $clog2((65535 / MEM_WORDS) + 1);
      localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

      logic [48:0]   prod;
      logic [QW-1:0] q_r;
      logic [15:0]   rem;

      // quotient by reciprocal multiply, registered with the address
      assign prod = 49'(raw) * 49'(RECIP);

      always_ff @(posedge clk) begin
        if (load) begin
          q_r <= prod[32 +: QW];
        end
      end

      // remainder = address - quotient * depth
      assign rem = raw_r - (16'(q_r) * 16'(MEM_WORDS));
      assign idx = rem[AW-1:0];
    end
  endgenerate

endmodule

@@ rtl/hpc_useq.sv @@
// Microcode sequencer: micro-program counter, ROM lookup, opcode dispatch
// and stall on a full response slot. Depends on hpc_pkg.
module hpc_useq
  import hpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_type,
  input  logic [3:0] opcode,
  input  logic       slot_free,
  output logic       req_ready,
  output logic       fin,
  output ctl_t       ctl
);

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  uword_t           uw;
  logic             stall;

  assign uw    = ucode_rom(upc);
  assign stall = (uw.seq == SQ_FIN) && !slot_free;

  // next micro-address
  always_comb begin
    upc_next = upc;
    unique case (uw.seq)
      SQ_ACCEPT: begin
        if (req_valid) begin
          upc_next = (req_type == REQ_EXEC) ? UA_FETCH : UA_LWR;
        end
      end
      SQ_NEXT:     upc_next = upc + UPC_W'(1);
      SQ_JUMP:     upc_next = uw.target;
      SQ_DISPATCH: upc_next = dispatch(opcode);
      SQ_FIN:      upc_next = slot_free ? UA_IDLE : upc;
      default:     upc_next = UA_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // control outputs
  always_comb begin
    req_ready     = (uw.seq == SQ_ACCEPT);
    fin           = (uw.seq == SQ_FIN) && slot_free;
    ctl.addr_sel  = uw.addr_sel;
    ctl.addr_en   = (uw.seq == SQ_ACCEPT) ? req_valid : uw.addr_en;
    ctl.latch_req = (uw.seq == SQ_ACCEPT) && req_valid;
    ctl.mem_rd    = uw.mem_rd;
    ctl.mem_wr    = uw.mem_wr;
    ctl.wd_sel    = uw.wd_sel;
    ctl.reg_op    = uw.reg_op;
    ctl.commit    = !stall;
  end

endmodule

@@ rtl/hpc_datapath.sv @@
// Datapath: pc, a, b and operand registers, shared adder, word memory with
// registered read, and the response value. Depends on hpc_pkg, hpc_addr_red.
module hpc_datapath
  import hpc_pkg::*;
#(
  parameter int unsigned MEM_WORDS = HPC_MEM_WORDS
) (
  input  logic       clk,
  input  logic       rst,
  input  ctl_t       ctl,
  input  req_t       req,
  output logic [3:0] opcode,
  output rsp_t       res
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [15:0]   pc, a, b, opr;
  logic [15:0]   pc_next, a_next, b_next, opr_next;
  logic [15:0]   load_data_r, in_data_r;
  logic [15:0]   rdata;
  logic [15:0]   mem [MEM_WORDS];
  logic [7:0]    ins;
  logic [15:0]   addend, sum, raw, wd;
  logic [AW-1:0] idx;

  // request payload held for later steps
  always_ff @(posedge clk) begin
    if (ctl.latch_req) begin
      load_data_r <= req.load_data;
      in_data_r   <= req.in_data;
    end
  end

  // instruction byte of the fetched word
  assign ins    = pc[0] ? rdata[15:8] : rdata[7:0];
  assign opcode = ins[7:4];

  // shared adder: base + operand
  always_comb begin
    addend = 16'h0000;
    case (ctl.reg_op)
      RO_A_PCREL, RO_PC_REL, RO_PC_REL_Z, RO_PC_REL_N: addend = pc;
      RO_PC_BREL: addend = b;
      default: begin
        case (ctl.addr_sel)
          ADDR_AO: addend = a;
          ADDR_BO: addend = b;
          default: addend = 16'h0000;
        endcase
      end
    endcase
  end
  assign sum = addend + opr;

  // memory address source
  always_comb begin
    case (ctl.addr_sel)
      ADDR_REQ: raw = (req.req_type == REQ_EXEC) ? {1'b0, pc[15:1]}
                                                 : {1'b0, req.load_addr};
      default:  raw = sum;
    endcase
  end

  hpc_addr_red #(
    .MEM_WORDS(MEM_WORDS)
  ) u_addr (
    .clk (clk),
    .load(ctl.addr_en),
    .raw (raw),
    .idx (idx)
  );

  // word memory
  assign wd = (ctl.wd_sel == WD_LOAD) ? load_data_r : a;

  always_ff @(posedge clk) begin
    if (ctl.mem_wr && ctl.commit) begin
      mem[idx] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_rd) begin
      rdata <= mem[idx];
    end
  end

  // register transfers and response value
  always_comb begin
    pc_next = pc;
    a_next  = a;
    b_next  = b;
    opr_next = opr;
    res.out_valid = 1'b0;
    res.out_word  = 16'h0000;
    res.out_port  = 16'h0000;
    res.in_taken  = 1'b0;
    res.in_port   = 16'h0000;
    case (ctl.reg_op)
      RO_DECODE: begin
        pc_next  = pc + 16'd1;
        opr_next = opr | {12'h000, ins[3:0]};
      end
      RO_A_MEM:    begin a_next = rdata; opr_next = 16'h0000; end
      RO_B_MEM:    begin b_next = rdata; opr_next = 16'h0000; end
      RO_A_OPR:    begin a_next = opr;   opr_next = 16'h0000; end
      RO_B_OPR:    begin b_next = opr;   opr_next = 16'h0000; end
      RO_A_PCREL:  begin a_next = sum;   opr_next = 16'h0000; end
      RO_PC_REL:   begin pc_next = sum;  opr_next = 16'h0000; end
      RO_PC_REL_Z: begin
        if (a == 16'h0000) begin
          pc_next = sum;
        end
        opr_next = 16'h0000;
      end
      RO_PC_REL_N: begin
        if (a[15]) begin
          pc_next = sum;
        end
        opr_next = 16'h0000;
      end
      RO_PC_BREL:  begin pc_next = sum;  opr_next = 16'h0000; end
      RO_OPERATE: begin
        // unknown operate codes keep everything, operand included
        case (opr)
          OPR_ADD: begin a_next = a + b; opr_next = 16'h0000; end
          OPR_SUB: begin a_next = a - b; opr_next = 16'h0000; end
          OPR_IN: begin
            res.in_taken = 1'b1;
            res.in_port  = a;
            a_next       = in_data_r;
            opr_next     = 16'h0000;
          end
          OPR_OUT: begin
            res.out_valid = 1'b1;
            res.out_word  = a;
            res.out_port  = b;
            opr_next      = 16'h0000;
          end
          default: opr_next = opr;
        endcase
      end
      RO_PFX: opr_next = {opr[11:0], 4'h0};
      RO_NFX: opr_next = NFIX_MASK | {opr[11:0], 4'h0};
      RO_CLR: opr_next = 16'h0000;
      default: opr_next = opr;
    endcase
    res.pc_now = pc_next;
    res.a_now  = a_next;
    res.b_now  = b_next;
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= 16'h0000;
      a   <= 16'h0000;
      b   <= 16'h0000;
      opr <= 16'h0000;
    end else if (ctl.commit) begin
      pc  <= pc_next;
      a   <= a_next;
      b   <= b_next;
      opr <= opr_next;
    end
  end

endmodule

@@ rtl/hex_processor_core_16bit.sv @@
// Steps: a load request is accepted, then written; an instruction is accepted,
// fetched and decoded, then executed for register ops and branches, addressed
// and written for stores, or addressed, read and written back for memory loads;
// response registered after. A new request is taken only once the last one has
// finished; each single-port memory access follows a registered address stage.
// Reset (rst, synchronous) clears pc, a, b, operand and sequencer; memory is not.
module hex_processor_core_16bit
  import hpc_pkg::*;
#(
  parameter int unsigned MEM_WORDS = HPC_MEM_WORDS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  ctl_t       ctl;
  logic [3:0] opcode;
  logic       fin;
  logic       slot_free;
  rsp_t       res;

  assign slot_free = !rsp_valid || rsp_ready;

  hpc_useq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_type (req.req_type),
    .opcode   (opcode),
    .slot_free(slot_free),
    .req_ready(req_ready),
    .fin      (fin),
    .ctl      (ctl)
  );

  hpc_datapath #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .req   (req),
    .opcode(opcode),
    .res   (res)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp <= res;
    end
  end

  // sequencer is busy right after it takes a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  // a finished instruction always lands in the response slot
  a_fin_lands: assert property (@(posedge clk) disable iff (rst)
    fin |=> rsp_valid)
    else $error("finished instruction lost");

  // input and output never reported for the same instruction
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.out_valid && rsp.in_taken))
    else $error("input and output both flagged");

  // idle output fields read zero
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.out_valid |-> rsp.out_word == 16'h0000 && rsp.out_port == 16'h0000)
    else $error("output fields set without output");

endmodule

@@ verif/tb_hex_processor_core_16bit.sv @@
// Self-checking testbench for hex_processor_core_16bit: builds a software model of
// the core's memory and registers, drives loads and instruction steps, compares responses.
// Depends on rtl/hpc_pkg.sv and rtl/hex_processor_core_16bit.sv.
`timescale 1ns / 100ps

module tb_hex_processor_core_16bit;
  import hpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // software copy of the core
  logic [15:0] mem_img [HPC_MEM_WORDS];
  bit          word_set [HPC_MEM_WORDS];
  logic [15:0] core_pc = '0;
  logic [15:0] core_a = '0;
  logic [15:0] core_b = '0;
  logic [15:0] core_opnd = '0;

  // responses still owed by the core, oldest first
  rsp_t due_states [$];

  int idle_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int failures = 0;
  int reqs_sent = 0;
  int n_steps = 0;
  int n_loads = 0;
  int n_in = 0;
  int n_out = 0;
  int n_unknown_opr = 0;
  int n_nfix = 0;
  bit [15:0] ops_seen = '0;

  hex_processor_core_16bit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // word addresses wrap to the memory depth
  function automatic logic [14:0] word_slot(input logic [15:0] addr);
    return 15'(addr % HPC_MEM_WORDS);
  endfunction

  function automatic void put_word(input logic [14:0] slot, input logic [15:0] data);
    mem_img[slot] = data;
    word_set[slot] = 1'b1;
  endfunction

  // advance the model by one request and return the state it should report
  function automatic rsp_t run_core_item(input req_t r);
    rsp_t s;
    logic [15:0] w;
    logic [15:0] o;
    logic [15:0] ea;
    logic [7:0] ins;
    logic keep_opnd;
    s = '0;
    if (r.req_type == REQ_LOAD) begin
      put_word(r.load_addr, r.load_data);
      n_loads++;
    end else begin
      w = mem_img[word_slot({1'b0, core_pc[15:1]})];
      ins = core_pc[0] ? w[15:8] : w[7:0];
      core_pc = core_pc + 16'd1;
      core_opnd = core_opnd | {12'd0, ins[3:0]};
      o = core_opnd;
      keep_opnd = 1'b0;
      ops_seen[ins[7:4]] = 1'b1;
      n_steps++;
      case (ins[7:4])
        OP_LDAM: core_a = mem_img[word_slot(o)];
        OP_LDBM: core_b = mem_img[word_slot(o)];
        OP_STAM: put_word(word_slot(o), core_a);
        OP_LDAC: core_a = o;
        OP_LDBC: core_b = o;
        OP_LDAP: core_a = core_pc + o;
        OP_LDAI: begin
          ea = core_a + o;
          core_a = mem_img[word_slot(ea)];
        end
        OP_LDBI: begin
          ea = core_b + o;
          core_b = mem_img[word_slot(ea)];
        end
        OP_STAI: begin
          ea = core_b + o;
          put_word(word_slot(ea), core_a);
        end
        OP_BR:   core_pc = core_pc + o;
        OP_BRZ:  if (core_a == 16'd0) core_pc = core_pc + o;
        OP_BRN:  if (core_a[15]) core_pc = core_pc + o;
        OP_BRB:  core_pc = core_b + o;
        OP_OPR: begin
          case (o)
            OPR_ADD: core_a = core_a + core_b;
            OPR_SUB: core_a = core_a - core_b;
            OPR_IN: begin
              s.in_taken = 1'b1;
              s.in_port = core_a;
              core_a = r.in_data;
              n_in++;
            end
            OPR_OUT: begin
              s.out_valid = 1'b1;
              s.out_word = core_a;
              s.out_port = core_b;
              n_out++;
            end
            default: begin
              // unknown sub-code: nothing changes, operand is kept
              keep_opnd = 1'b1;
              n_unknown_opr++;
            end
          endcase
        end
        OP_PFIX: begin
          core_opnd = o << 4;
          keep_opnd = 1'b1;
        end
        OP_NFIX: begin
          // shifted value is cut to 16 bits before the high byte is forced
          core_opnd = NFIX_MASK | (o << 4);
          keep_opnd = 1'b1;
          n_nfix++;
        end
      endcase
      if (!keep_opnd) core_opnd = '0;
    end
    s.pc_now = core_pc;
    s.a_now = core_a;
    s.b_now = core_b;
    return s;
  endfunction

  // one request over the handshake, with an optional gap first
  task automatic send_req(input req_t r);
    rsp_t exp_state;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    exp_state = run_core_item(r);
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    due_states.push_back(exp_state);
    reqs_sent++;
  endtask

  task automatic send_load(input logic [14:0] addr, input logic [15:0] data);
    req_t r;
    r.req_type = REQ_LOAD;
    r.load_addr = addr;
    r.load_data = data;
    r.in_data = 16'($urandom);
    send_req(r);
  endtask

  // instruction byte biased toward operate and prefixes
  function automatic logic [7:0] pick_instr();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      if ($urandom_range(0, 99) < 85) return {OP_OPR, 4'($urandom_range(0, 3))};
      return {OP_OPR, 4'($urandom_range(4, 15))};
    end
    if (pick < 34) return {($urandom_range(0, 1) ? OP_PFIX : OP_NFIX), 4'($urandom)};
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_in();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // one instruction step; words it would read are written first if still unset
  task automatic run_step(input logic [15:0] din);
    logic [14:0] fetch_slot;
    logic [15:0] o;
    logic [15:0] ea;
    logic [7:0] ins;
    logic reads;
    req_t r;
    fetch_slot = word_slot({1'b0, core_pc[15:1]});
    if (!word_set[fetch_slot]) send_load(fetch_slot, {pick_instr(), pick_instr()});
    ins = core_pc[0] ? mem_img[fetch_slot][15:8] : mem_img[fetch_slot][7:0];
    o = core_opnd | {12'd0, ins[3:0]};
    reads = 1'b1;
    case (ins[7:4])
      OP_LDAM, OP_LDBM: ea = o;
      OP_LDAI: ea = core_a + o;
      OP_LDBI: ea = core_b + o;
      default: begin
        ea = '0;
        reads = 1'b0;
      end
    endcase
    if (reads && !word_set[word_slot(ea)]) send_load(word_slot(ea), 16'($urandom));
    r.req_type = REQ_EXEC;
    r.load_addr = 15'($urandom);
    r.load_data = 16'($urandom);
    r.in_data = din;
    send_req(r);
  endtask

  // write a byte string of code starting at a byte address
  task automatic load_code(input logic [15:0] at, input logic [7:0] code [$]);
    logic [15:0] ba;
    logic [15:0] w;
    int i;
    i = 0;
    while (i < code.size()) begin
      ba = at + 16'(i);
      w = word_set[word_slot({1'b0, ba[15:1]})] ? mem_img[word_slot({1'b0, ba[15:1]})]
                                                 : 16'($urandom);
      if (ba[0]) begin
        w[15:8] = code[i];
      end else begin
        w[7:0] = code[i];
      end
      i++;
      if (!ba[0] && i < code.size()) begin
        w[15:8] = code[i];
        i++;
      end
      send_load(word_slot({1'b0, ba[15:1]}), w);
    end
  endtask

  // compare one response with the oldest expectation
  task automatic check_rsp(input rsp_t got);
    rsp_t exp_state;
    bit bad;
    if (due_states.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("unexpected response: pc=%h a=%h b=%h", got.pc_now, got.a_now, got.b_now);
    end else begin
      exp_state = due_states.pop_front();
      bad = (got.pc_now !== exp_state.pc_now) || (got.a_now !== exp_state.a_now)
         || (got.b_now !== exp_state.b_now) || (got.out_valid !== exp_state.out_valid)
         || (got.out_word !== exp_state.out_word) || (got.out_port !== exp_state.out_port)
         || (got.in_taken !== exp_state.in_taken) || (got.in_port !== exp_state.in_port);
      if (bad) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch exp: pc=%h a=%h b=%h out=%b/%h/%h in=%b/%h",
                   exp_state.pc_now, exp_state.a_now, exp_state.b_now, exp_state.out_valid,
                   exp_state.out_word, exp_state.out_port, exp_state.in_taken,
                   exp_state.in_port);
          $display("         got: pc=%h a=%h b=%h out=%b/%h/%h in=%b/%h",
                   got.pc_now, got.a_now, got.b_now, got.out_valid, got.out_word,
                   got.out_port, got.in_taken, got.in_port);
        end
      end
    end
  endtask

  // response side: check, then stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && rsp_ready) check_rsp(rsp);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left <= $urandom_range(0, 16);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // load extremes: top word address, all-ones data
  task automatic test_load_extremes();
    send_load(15'h7FFF, 16'hFFFF);
  endtask

  // walk through every opcode, operate sub-code, taken branches and the
  // negative prefix whose shifted operand loses its top bits
  task automatic test_opcode_walk();
    logic [7:0] prog [$];
    prog = {{OP_LDAC, 4'h5}, {OP_LDBC, 4'h3}, {OP_OPR, 4'h0}, {OP_OPR, 4'h1},
            {OP_STAM, 4'hF}, {OP_LDBM, 4'hF}, {OP_LDAM, 4'hF}, {OP_LDAP, 4'h2},
            {OP_LDAI, 4'h1}, {OP_STAI, 4'hF}, {OP_LDBI, 4'h0}, {OP_OPR, 4'h2},
            {OP_OPR, 4'h3}, {OP_LDAC, 4'h0}, {OP_BRZ, 4'h1}, {OP_OPR, 4'h0},
            {OP_NFIX, 4'h1}, {OP_NFIX, 4'h2}, {OP_LDAC, 4'h0}, {OP_BRN, 4'h1},
            {OP_OPR, 4'h0}, {OP_BR, 4'h0}, {OP_OPR, 4'h9}, {OP_PFIX, 4'h1},
            {OP_BRB, 4'h0}};
    load_code(core_pc, prog);
    repeat (23) run_step(16'hFFFF);
  endtask

  // random instruction streams, with noise loads and rewrites of the word at pc
  task automatic test_random_programs(input int n_items, input bit with_idle);
    int target;
    int pick;
    target = reqs_sent + n_items;
    while (reqs_sent < target) begin
      if (with_idle && $urandom_range(0, 99) == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_load(15'($urandom), 16'($urandom));
      end else if (pick < 9) begin
        send_load(word_slot({1'b0, core_pc[15:1]}), {pick_instr(), pick_instr()});
      end else begin
        run_step(pick_in());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 20;
    test_load_extremes();
    test_opcode_walk();
    idle_pct = 10;
    test_random_programs(1400, 1'b1);
    idle_pct = 0;
    test_random_programs(300, 1'b0);
    req_valid <= 1'b0;

    while (due_states.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d requests: %0d instruction steps, %0d memory loads, %0d of 16 opcodes",
             reqs_sent, n_steps, n_loads, $countones(ops_seen));
    $display("operate: %0d input, %0d output, %0d unknown; %0d negative prefixes; %0d failures",
             n_in, n_out, n_unknown_opr, n_nfix, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
